[rtl/core/line_xor_word_checksum_core_assert.svh]
// Assertion macros shared by the checksum core RTL.
`ifndef LINE_XOR_WORD_CHECKSUM_CORE_ASSERT_SVH
`define LINE_XOR_WORD_CHECKSUM_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LXWC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LXWC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/lxwc_pkg.sv]
// Types and helper functions for the line XOR word checksum core.
`timescale 1ns / 1ps
`default_nettype none

package lxwc_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned WordW = 32;
  localparam int unsigned PosW  = 2;
  localparam logic [PosW-1:0] LastSlot = 2'd3;

  typedef struct packed {
    logic             restart;
    logic             line_end;
    logic [ByteW-1:0] text_byte;
  } item_t;

  typedef struct packed {
    logic [WordW-1:0] line_count;
    logic [WordW-1:0] checksum;
  } result_t;

  function automatic logic [WordW-1:0] bswap32(input logic [WordW-1:0] w);
    bswap32 = {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  // Rotate left by whole bytes: byte slot k moves to slot k + pos.
  function automatic logic [WordW-1:0] rotl_bytes(input logic [WordW-1:0] w,
                                                 input logic [PosW-1:0]  pos);
    case (pos)
      2'd0:    rotl_bytes = w;
      2'd1:    rotl_bytes = {w[23:0], w[31:24]};
      2'd2:    rotl_bytes = {w[15:0], w[31:16]};
      default: rotl_bytes = {w[7:0], w[31:8]};
    endcase
  endfunction

endpackage

`default_nettype wire

[rtl/core/lxwc_in_reg.sv]
// Input register stage: captures one transaction and holds it until taken.
`timescale 1ns / 1ps
`default_nettype none

module lxwc_in_reg (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire lxwc_pkg::item_t in_item,
  output logic                 in_ready,
  input  wire logic            take,
  output logic                 item_valid,
  output lxwc_pkg::item_t      item
);
  import lxwc_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  load;

  // Refill in the same cycle the held item is taken.
  assign in_ready  = !valid_r || take;
  assign load      = in_valid && in_ready;
  assign valid_nxt = load ? 1'b1 : (take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

[rtl/core/lxwc_engine.sv]
// Checksum state, single-pass update logic and result register.
`timescale 1ns / 1ps
`default_nettype none

`include "line_xor_word_checksum_core_assert.svh"

module lxwc_engine (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            big_endian,
  input  wire logic            adv,
  input  wire lxwc_pkg::item_t item,
  output lxwc_pkg::result_t    result
);
  import lxwc_pkg::*;

  logic [WordW-1:0] sum_r,     sum_nxt;
  logic [WordW-1:0] partial_r, partial_nxt;
  logic [PosW-1:0]  pos_r,     pos_nxt;
  logic [WordW-1:0] lines_r,   lines_nxt;
  result_t          result_r;

  logic [WordW-1:0] sum_base, partial_base, lines_base;
  logic [PosW-1:0]  pos_base;
  logic [WordW-1:0] line_bytes, line_fold, byte_word;

  always_comb begin
    // Restart clears everything before the item is applied.
    sum_base     = item.restart ? '0 : sum_r;
    partial_base = item.restart ? '0 : partial_r;
    pos_base     = item.restart ? '0 : pos_r;
    lines_base   = item.restart ? '0 : lines_r;

    // Line number bytes in emit order, slot 0 in the low byte.
    line_bytes = big_endian ? bswap32(lines_base) : lines_base;
    // Both words touched by the line number, XORed together; packing is linear.
    line_fold  = partial_base ^ rotl_bytes(line_bytes, pos_base);
    byte_word  = partial_base |
                 (WordW'(item.text_byte) << {pos_base, 3'b000});

    sum_nxt     = sum_base;
    partial_nxt = partial_base;
    pos_nxt     = pos_base;
    lines_nxt   = lines_base;

    if (item.line_end) begin
      sum_nxt     = sum_base ^ (big_endian ? bswap32(line_fold) : line_fold);
      partial_nxt = '0;
      pos_nxt     = '0;
      lines_nxt   = lines_base + 32'd1;
    end else if (item.text_byte != '0) begin
      pos_nxt = pos_base + 2'd1;
      if (pos_base == LastSlot) begin
        sum_nxt     = sum_base ^ (big_endian ? bswap32(byte_word) : byte_word);
        partial_nxt = '0;
      end else begin
        partial_nxt = byte_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r     <= '0;
      partial_r <= '0;
      pos_r     <= '0;
      lines_r   <= '0;
    end else if (adv) begin
      sum_r     <= sum_nxt;
      partial_r <= partial_nxt;
      pos_r     <= pos_nxt;
      lines_r   <= lines_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result_r.checksum   <= sum_nxt;
      result_r.line_count <= lines_nxt;
    end
  end

  assign result = result_r;

  `LXWC_ASSERT_NEXT(a_line_end_clears_pos, clk, rst_n, adv && item.line_end,
    pos_r == '0 && partial_r == '0, "line end left a partial word")
  `LXWC_ASSERT_NOW(a_empty_word_zero, clk, rst_n, pos_r == '0, partial_r == '0,
    "partial word holds bytes at slot zero")
  `LXWC_ASSERT_NEXT(a_line_count_step, clk, rst_n,
    adv && item.line_end && !item.restart,
    lines_r == $past(lines_r) + 32'd1, "line count did not advance by one")
  `LXWC_ASSERT_NEXT(a_restart_clears, clk, rst_n,
    adv && item.restart && !item.line_end,
    lines_r == '0, "restart did not clear the line count")

endmodule

`default_nettype wire

[rtl/core/line_xor_word_checksum_core.sv]
// Top level of the line XOR word checksum core.
//
//  Channel  Direction  Signals                     Contents
//  in       slave      in_tvalid/tready/tdata/...  text byte, line end (tlast), restart (tuser)
//  out      master     out_tvalid/tready/tdata     checksum, line count
//  cfg      write-only cfg_wr_en/cfg_wr_data       big-endian packing select
//
// One input transaction is taken per cycle unless out_tready stalls; one result per transaction.
// An input passes through the input register, then the update logic into the
// result register; state and result register load in the same cycle.
// The throughput limit is the state update loop (checksum, partial word,
// byte slot, line count), which completes every cycle unless out_tready stalls.
// rst_n is synchronous, active low; it clears state, valid flags and packing.
// A stall on out_tready holds the result and at most one more held input.
`timescale 1ns / 1ps
`default_nettype none

`include "line_xor_word_checksum_core_assert.svh"

module line_xor_word_checksum_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] text_byte
  input  wire logic        in_tlast,   // line_end
  input  wire logic        in_tuser,   // restart
  // Result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // [31:0] checksum, [63:32] line_count
  // Configuration
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data // big_endian_packing
);
  import lxwc_pkg::*;

  item_t   in_item;
  item_t   item;
  result_t result;
  logic    item_valid;
  logic    adv;
  logic    big_endian_r;
  logic    out_valid_r, out_valid_nxt;

  assign in_item.text_byte = in_tdata;
  assign in_item.line_end  = in_tlast;
  assign in_item.restart   = in_tuser;

  // Advance the held item whenever the result register is free or draining.
  assign adv = item_valid && (!out_valid_r || out_tready);

  lxwc_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_item    (in_item),
    .in_ready   (in_tready),
    .take       (adv),
    .item_valid (item_valid),
    .item       (item)
  );

  lxwc_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .big_endian (big_endian_r),
    .adv        (adv),
    .item       (item),
    .result     (result)
  );

  // Hold the result until taken; drop valid only when nothing replaces it.
  assign out_valid_nxt = adv ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      big_endian_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        big_endian_r <= cfg_wr_data;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {result.line_count, result.checksum};

  `LXWC_ASSERT_NEXT(a_adv_gives_result, clk, rst_n, adv, out_valid_r,
    "advanced transaction produced no result")
  `LXWC_ASSERT_NOW(a_adv_needs_room, clk, rst_n, adv,
    item_valid && (!out_valid_r || out_tready), "advance over a pending result")
  `LXWC_ASSERT_NEXT(a_stall_holds_result, clk, rst_n, out_valid_r && !out_tready,
    out_valid_r && $stable(out_tdata), "stalled result changed")

endmodule

`default_nettype wire
